>>> design/sstq_pkg.sv
// shared types and codes for the sorted sleep timer queue
package sstq_pkg;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_TICK,
        CELL_SHIFT
    } cell_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } ctrl_state_t;

    localparam logic ACTION_TICK  = 1'b0;
    localparam logic ACTION_SLEEP = 1'b1;

    localparam logic [1:0] KIND_WOKEN    = 2'd0;
    localparam logic [1:0] KIND_ACCEPTED = 2'd1;
    localparam logic [1:0] KIND_FULL     = 2'd2;
    localparam logic [1:0] KIND_ZERO     = 2'd3;

endpackage

>>> design/sorted_sleep_timer_queue.sv
// sorted sleep timer queue: a chain of cells kept in ascending remaining time
// sleep beat: the result is registered in the output register on acceptance;
//   with m_ready held high a new beat is taken every cycle
// tick beat: the tick decrements every valid cell, then one woken thread leaves the head
//   cell per cycle while the output is free, until the head is found not expired
// reset (aresetn low, synchronous) empties every cell and drops any pending result
module sorted_sleep_timer_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_BITS   = 32,
    parameter int ID_BITS     = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_action,
    input  logic [ID_BITS-1:0]   s_thread_id,
    input  logic [TIME_BITS-1:0] s_sleep_time,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_kind,
    output logic [ID_BITS-1:0]   m_woken_thread,
    output logic                 m_last
);

    sstq_pkg::ctrl_state_t state_reg, state_next;
    sstq_pkg::cell_op_t    cell_op;

    logic                 m_valid_reg, m_valid_next;
    logic [1:0]           m_kind_reg, m_kind_next;
    logic [ID_BITS-1:0]   m_id_reg, m_id_next;
    logic                 m_last_reg, m_last_next;

    logic                 c_valid [QUEUE_DEPTH];
    logic [TIME_BITS-1:0] c_time  [QUEUE_DEPTH];
    logic [ID_BITS-1:0]   c_id    [QUEUE_DEPTH];
    logic                 c_keep  [QUEUE_DEPTH];

    logic out_free;
    logic accept;
    logic full;
    logic head_expired;
    logic next_expired;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            logic                 lv, lk, rv;
            logic [TIME_BITS-1:0] lt, rt;
            logic [ID_BITS-1:0]   li, ri;
            if (gi == 0) begin : g_first
                assign lv = 1'b0;
                assign lt = '0;
                assign li = '0;
                assign lk = 1'b1;
            end else begin : g_mid
                assign lv = c_valid[gi-1];
                assign lt = c_time[gi-1];
                assign li = c_id[gi-1];
                assign lk = c_keep[gi-1];
            end
            if (gi == QUEUE_DEPTH - 1) begin : g_end
                assign rv = 1'b0;
                assign rt = '0;
                assign ri = '0;
            end else begin : g_inner
                assign rv = c_valid[gi+1];
                assign rt = c_time[gi+1];
                assign ri = c_id[gi+1];
            end
            sstq_cell #(
                .TIME_BITS (TIME_BITS),
                .ID_BITS   (ID_BITS)
            ) u_cell (
                .aclk          (aclk),
                .aresetn       (aresetn),
                .op_i          (cell_op),
                .ins_time_i    (s_sleep_time),
                .ins_id_i      (s_thread_id),
                .left_valid_i  (lv),
                .left_time_i   (lt),
                .left_id_i     (li),
                .left_keep_i   (lk),
                .right_valid_i (rv),
                .right_time_i  (rt),
                .right_id_i    (ri),
                .valid_o       (c_valid[gi]),
                .time_o        (c_time[gi]),
                .id_o          (c_id[gi]),
                .keep_o        (c_keep[gi])
            );
        end
    endgenerate

    assign out_free     = !m_valid_reg || m_ready;
    assign s_ready      = (state_reg == sstq_pkg::ST_IDLE) && out_free;
    assign accept       = s_valid && s_ready;
    assign full         = c_valid[QUEUE_DEPTH-1];
    assign head_expired = c_valid[0] && (c_time[0] == '0);
    assign next_expired = c_valid[1] && (c_time[1] == '0);

    always_comb begin
        state_next   = state_reg;
        cell_op      = sstq_pkg::CELL_HOLD;
        m_valid_next = m_valid_reg && !m_ready;
        m_kind_next  = m_kind_reg;
        m_id_next    = m_id_reg;
        m_last_next  = m_last_reg;
        case (state_reg)
            sstq_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_action == sstq_pkg::ACTION_SLEEP) begin
                        m_valid_next = 1'b1;
                        m_id_next    = s_thread_id;
                        m_last_next  = 1'b1;
                        if (s_sleep_time == '0) begin
                            m_kind_next = sstq_pkg::KIND_ZERO;
                        end else if (full) begin
                            m_kind_next = sstq_pkg::KIND_FULL;
                        end else begin
                            m_kind_next = sstq_pkg::KIND_ACCEPTED;
                            cell_op     = sstq_pkg::CELL_INSERT;
                        end
                    end else begin
                        cell_op    = sstq_pkg::CELL_TICK;
                        state_next = sstq_pkg::ST_DRAIN;
                    end
                end
            end
            sstq_pkg::ST_DRAIN: begin
                // expired entries form a prefix; pop them from the head one per beat
                if (head_expired) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_kind_next  = sstq_pkg::KIND_WOKEN;
                        m_id_next    = c_id[0];
                        m_last_next  = !next_expired;
                        cell_op      = sstq_pkg::CELL_SHIFT;
                    end
                end else begin
                    state_next = sstq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sstq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sstq_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        m_kind_reg <= m_kind_next;
        m_id_reg   <= m_id_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = m_kind_reg;
    assign m_woken_thread = m_id_reg;
    assign m_last         = m_last_reg;

endmodule

>>> design/sstq_cell.sv
// one queue cell: holds an entry and trades it with its neighbors
module sstq_cell #(
    parameter int TIME_BITS = 32,
    parameter int ID_BITS   = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sstq_pkg::cell_op_t   op_i,
    input  logic [TIME_BITS-1:0] ins_time_i,
    input  logic [ID_BITS-1:0]   ins_id_i,
    input  logic                 left_valid_i,
    input  logic [TIME_BITS-1:0] left_time_i,
    input  logic [ID_BITS-1:0]   left_id_i,
    input  logic                 left_keep_i,
    input  logic                 right_valid_i,
    input  logic [TIME_BITS-1:0] right_time_i,
    input  logic [ID_BITS-1:0]   right_id_i,
    output logic                 valid_o,
    output logic [TIME_BITS-1:0] time_o,
    output logic [ID_BITS-1:0]   id_o,
    output logic                 keep_o
);

    logic                 valid_reg, valid_next;
    logic [TIME_BITS-1:0] time_reg, time_next;
    logic [ID_BITS-1:0]   id_reg, id_next;

    // entries at or below the new time stay put, so equal times keep arrival order
    assign keep_o = valid_reg && (time_reg <= ins_time_i);

    always_comb begin
        valid_next = valid_reg;
        time_next  = time_reg;
        id_next    = id_reg;
        case (op_i)
            sstq_pkg::CELL_INSERT: begin
                if (!keep_o) begin
                    if (left_keep_i) begin
                        valid_next = 1'b1;
                        time_next  = ins_time_i;
                        id_next    = ins_id_i;
                    end else begin
                        valid_next = left_valid_i;
                        time_next  = left_time_i;
                        id_next    = left_id_i;
                    end
                end
            end
            sstq_pkg::CELL_TICK: begin
                if (valid_reg && (time_reg != '0)) begin
                    time_next = time_reg - TIME_BITS'(1);
                end
            end
            sstq_pkg::CELL_SHIFT: begin
                valid_next = right_valid_i;
                time_next  = right_time_i;
                id_next    = right_id_i;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        time_reg <= time_next;
        id_reg   <= id_next;
    end

    assign valid_o = valid_reg;
    assign time_o  = time_reg;
    assign id_o    = id_reg;

endmodule
